/* hdl/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_CLK_NORST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/gkn_pkg.sv */
package gkn_pkg;
	localparam int MAX_CORNERS = 64;
	localparam int MAX_DIM     = 1024;
	localparam int FRAC_BITS   = 4;
	localparam int IDX_W  = $clog2(MAX_CORNERS);
	localparam int CNT_W  = $clog2(MAX_CORNERS + 1);
	localparam int CELL_W = $clog2(MAX_DIM);
	localparam int COORD_W = 14;
	localparam int SCORE_W = 16;
	localparam int DIM_W   = 11;
	localparam int RAD_W   = 10;
	localparam int CFG_W   = 11;

	localparam logic [1:0] REG_GRID_HEIGHT = 2'd0;
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
	localparam logic [1:0] REG_RADIUS      = 2'd2;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_CHECK,
		ST_LIST,
		ST_FETCH,
		ST_EMIT
	} gkn_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;         // store the input beat
		logic start_scan;   // reset scan index and best
		logic scan_step;    // read one entry, compare the previous one
		logic fetch;        // read the chosen corner, begin the kept list walk
		logic check_step;
		logic take;         // mark chosen as used
		logic keep;         // append chosen to the kept list
		logic start_emit;
		logic read_list;    // read the next kept list entry
		logic fetch_emit;   // read the corner named by that entry
		logic emit_step;
		logic clr;          // empty the store after the last kept beat
	} gkn_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;     // every entry read and compared
		logic found;        // scan found an unused corner
		logic hit;          // chosen corner lies near a kept one
		logic check_end;    // kept list walked without a hit
		logic emit_last;
		logic store_full;
	} gkn_sts_t;

	function automatic logic [CELL_W-1:0] to_cell(input logic [COORD_W-1:0] v,
			input logic [DIM_W-1:0] size);
		logic [COORD_W:0]   sum;
		logic [COORD_W:0]   c;
		logic [DIM_W-1:0]   sz;
		logic [DIM_W-1:0]   last;
		sum = {1'b0, v} + (COORD_W+1)'((1 << FRAC_BITS) >> 1);
		c = sum >> FRAC_BITS;
		if (size == '0)
			sz = DIM_W'(1);
		else if (size > DIM_W'(MAX_DIM))
			sz = DIM_W'(MAX_DIM);
		else
			sz = size;
		last = sz - DIM_W'(1);
		if (c > (COORD_W+1)'(last))
			return CELL_W'(last);
		return CELL_W'(c);
	endfunction
endpackage

/* hdl/gkn_ctrl.sv */
module gkn_ctrl import gkn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     final_corner,
	output logic     out_valid,
	input  logic     out_ready,
	input  gkn_sts_t sts,
	output gkn_cmd_t cmd
);
	gkn_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (in_valid && final_corner) state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_end)
					state_d = sts.found ? ST_CHECK : ST_LIST;
			end
			ST_CHECK: if (sts.hit || sts.check_end) state_d = ST_SCAN;
			ST_LIST: state_d = ST_FETCH;
			ST_FETCH: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready)
					state_d = sts.emit_last ? ST_LOAD : ST_LIST;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid && !sts.store_full;
				cmd.start_scan = in_valid && final_corner;
			end
			ST_SCAN: begin
				cmd.scan_step = !sts.scan_end;
				cmd.fetch = sts.scan_end && sts.found;
				cmd.start_emit = sts.scan_end && !sts.found;
			end
			ST_CHECK: begin
				if (sts.hit || sts.check_end) begin
					cmd.take = 1'b1;
					cmd.keep = !sts.hit;
					cmd.start_scan = 1'b1;
				end else
					cmd.check_step = 1'b1;
			end
			ST_LIST: cmd.read_list = 1'b1;
			ST_FETCH: cmd.fetch_emit = 1'b1;
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.emit_step = out_ready && !sts.emit_last;
				cmd.clr = out_ready && sts.emit_last;
			end
			default: cmd = '0;
		endcase
	end
endmodule

/* hdl/gkn_datapath.sv */
module gkn_datapath import gkn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic [COORD_W-1:0] corner_x,
	input  logic [COORD_W-1:0] corner_y,
	input  logic [SCORE_W-1:0] corner_score,
	input  gkn_cmd_t           cmd,
	output gkn_sts_t           sts,
	output logic [IDX_W-1:0]   kept_index,
	output logic [COORD_W-1:0] kept_x,
	output logic [COORD_W-1:0] kept_y,
	output logic [SCORE_W-1:0] kept_score,
	output logic               last_kept
);
	logic [DIM_W-1:0] grid_height_q, grid_width_q;
	logic [RAD_W-1:0] radius_q;

	logic [COORD_W-1:0] mem_x [MAX_CORNERS];
	logic [COORD_W-1:0] mem_y [MAX_CORNERS];
	logic [SCORE_W-1:0] mem_s [MAX_CORNERS];
	// kept list in selection order: load index and cells
	logic [IDX_W-1:0]   kl_mem [MAX_CORNERS];
	logic [CELL_W-1:0]  kcx_mem [MAX_CORNERS];
	logic [CELL_W-1:0]  kcy_mem [MAX_CORNERS];

	logic [CNT_W-1:0]   count_q, scan_q, nkept_q, chk_q, emit_q;
	logic [MAX_CORNERS-1:0] used_q;
	logic               found_q;
	logic [IDX_W-1:0]   best_q, rd_idx_q, kl_rd_q;
	logic [SCORE_W-1:0] best_s_q;
	logic               rd_vld_q, kc_vld_q;
	logic [COORD_W-1:0] rd_x_q, rd_y_q;
	logic [SCORE_W-1:0] rd_s_q;
	logic [CELL_W-1:0]  kcx_q, kcy_q;
	logic [CELL_W-1:0]  ccx, ccy, dx, dy;
	logic               scan_rd, chk_rd, rd_en, hit;
	logic [IDX_W-1:0]   rd_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_height_q <= DIM_W'(480);
			grid_width_q <= DIM_W'(640);
			radius_q <= RAD_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
				REG_GRID_WIDTH:  grid_width_q <= cfg_data;
				REG_RADIUS:      radius_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign scan_rd = cmd.scan_step && (scan_q != count_q);
	assign chk_rd = cmd.check_step && (chk_q != nkept_q);

	// one read port on the store, shared by scan, check and emit
	always_comb begin
		rd_addr = scan_q[IDX_W-1:0];
		if (cmd.fetch)
			rd_addr = best_q;
		else if (cmd.fetch_emit)
			rd_addr = kl_rd_q;
	end
	assign rd_en = scan_rd || cmd.fetch || cmd.fetch_emit;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_x[count_q[IDX_W-1:0]] <= corner_x;
			mem_y[count_q[IDX_W-1:0]] <= corner_y;
			mem_s[count_q[IDX_W-1:0]] <= corner_score;
		end
		if (rd_en) begin
			rd_x_q <= mem_x[rd_addr];
			rd_y_q <= mem_y[rd_addr];
			rd_s_q <= mem_s[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.keep) begin
			kl_mem[nkept_q[IDX_W-1:0]] <= best_q;
			kcx_mem[nkept_q[IDX_W-1:0]] <= ccx;
			kcy_mem[nkept_q[IDX_W-1:0]] <= ccy;
		end
		if (chk_rd) begin
			kcx_q <= kcx_mem[chk_q[IDX_W-1:0]];
			kcy_q <= kcy_mem[chk_q[IDX_W-1:0]];
		end
		if (cmd.read_list)
			kl_rd_q <= kl_mem[emit_q[IDX_W-1:0]];
	end

	assign ccx = to_cell(rd_x_q, grid_width_q);
	assign ccy = to_cell(rd_y_q, grid_height_q);
	assign dx = (ccx > kcx_q) ? ccx - kcx_q : kcx_q - ccx;
	assign dy = (ccy > kcy_q) ? ccy - kcy_q : kcy_q - ccy;
	assign hit = kc_vld_q && (dx <= radius_q) && (dy <= radius_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q <= '0;
			scan_q <= '0;
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_s_q <= '0;
			nkept_q <= '0;
			chk_q <= '0;
			kc_vld_q <= 1'b0;
			emit_q <= '0;
		end else begin
			if (cmd.load)
				count_q <= count_q + CNT_W'(1);
			if (cmd.start_scan) begin
				scan_q <= '0;
				rd_vld_q <= 1'b0;
				found_q <= 1'b0;
			end
			// read data lags the index by one; compare the entry read last cycle
			if (cmd.scan_step) begin
				if (scan_rd)
					scan_q <= scan_q + CNT_W'(1);
				rd_vld_q <= scan_rd;
				rd_idx_q <= scan_q[IDX_W-1:0];
				if (rd_vld_q && !used_q[rd_idx_q] && (!found_q || rd_s_q > best_s_q)) begin
					found_q <= 1'b1;
					best_q <= rd_idx_q;
					best_s_q <= rd_s_q;
				end
			end
			if (cmd.fetch) begin
				chk_q <= '0;
				kc_vld_q <= 1'b0;
			end
			if (cmd.check_step) begin
				if (chk_rd)
					chk_q <= chk_q + CNT_W'(1);
				kc_vld_q <= chk_rd;
			end
			if (cmd.take)
				used_q[best_q] <= 1'b1;
			if (cmd.keep)
				nkept_q <= nkept_q + CNT_W'(1);
			if (cmd.start_emit)
				emit_q <= '0;
			if (cmd.emit_step)
				emit_q <= emit_q + CNT_W'(1);
			if (cmd.clr) begin
				count_q <= '0;
				used_q <= '0;
				nkept_q <= '0;
			end
		end
	end

	assign sts.scan_end = (scan_q == count_q) && !rd_vld_q;
	assign sts.found = found_q;
	assign sts.hit = hit;
	assign sts.check_end = (chk_q == nkept_q) && !kc_vld_q;
	assign sts.emit_last = (emit_q + CNT_W'(1)) == nkept_q;
	assign sts.store_full = count_q == CNT_W'(MAX_CORNERS);

	assign kept_index = kl_rd_q;
	assign kept_x = rd_x_q;
	assign kept_y = rd_y_q;
	assign kept_score = rd_s_q;
	assign last_kept = sts.emit_last;
endmodule

/* hdl/grid_keypoint_nms.sv */
// channel | dir | beat
// in      | in  | corner_x, corner_y, corner_score, final_corner
// out     | out | kept_index, kept_x, kept_y, kept_score, last_kept
// cfg     | in  | cfg_we, cfg_index, cfg_data
// loading accepts one corner per cycle; the final beat starts selection
// selection: per chosen corner one scan over the store for the best unused score,
// then a walk of the kept list, ended early by a hit
// emit: per kept corner a kept list read, a store read, then the beat held in the emit state until taken
// input is stalled from the final beat until the last kept beat is taken
// after reset the store is empty and loading starts at once
module grid_keypoint_nms import gkn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] corner_x,
	input  logic [COORD_W-1:0] corner_y,
	input  logic [SCORE_W-1:0] corner_score,
	input  logic               final_corner,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   kept_index,
	output logic [COORD_W-1:0] kept_x,
	output logic [COORD_W-1:0] kept_y,
	output logic [SCORE_W-1:0] kept_score,
	output logic               last_kept
);
	gkn_cmd_t cmd;
	gkn_sts_t sts;

	gkn_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .final_corner,
		.out_valid, .out_ready, .sts, .cmd
	);

	gkn_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.corner_x, .corner_y, .corner_score, .cmd, .sts,
		.kept_index, .kept_x, .kept_y, .kept_score, .last_kept
	);
endmodule

/* hdl/gkn_checker.sv */
`include "assert_macros.svh"
module gkn_checker import gkn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [SCORE_W-1:0] kept_score
);
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "out beat dropped")
	`ASSERT_CLK(a_score_hold, clk, arst_n, out_valid && !out_ready |=> $stable(kept_score), "score moved")
	`ASSERT_CLK(a_no_overlap, clk, arst_n, !(in_ready && out_valid), "load during emit")
	`ASSERT_CLK_NORST(a_rst, clk, !arst_n |-> !out_valid, "valid in reset")
endmodule

bind grid_keypoint_nms gkn_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .kept_score
);

/* bench/grid_keypoint_nms_checker.sv */
module grid_keypoint_nms_checker import gkn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [COORD_W-1:0] corner_x,
	input  logic [COORD_W-1:0] corner_y,
	input  logic [SCORE_W-1:0] corner_score,
	input  logic               final_corner,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [IDX_W-1:0]   kept_index,
	input  logic [COORD_W-1:0] kept_x,
	input  logic [COORD_W-1:0] kept_y,
	input  logic [SCORE_W-1:0] kept_score,
	input  logic               last_kept,
	output int                 fail_count,
	output int                 pending,
	output int                 kept_seen,
	output int                 sets_seen
);
	typedef struct packed {
		logic [IDX_W-1:0]   idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SCORE_W-1:0] score;
		logic               last;
	} kept_t;

	kept_t kept_q[$];
	logic [DIM_W-1:0] m_height, m_width;
	logic [RAD_W-1:0] m_radius;
	logic [COORD_W-1:0] sx[MAX_CORNERS];
	logic [COORD_W-1:0] sy[MAX_CORNERS];
	logic [SCORE_W-1:0] ss[MAX_CORNERS];
	int count;

	function automatic int cell_of(int v, int size);
		int c, sz;
		c = (v + ((1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
		sz = size < 1 ? 1 : (size > MAX_DIM ? MAX_DIM : size);
		return c > sz - 1 ? sz - 1 : c;
	endfunction

	function automatic int abs_diff(int a, int b);
		return a > b ? a - b : b - a;
	endfunction

	// select survivors of the loaded set and queue them in selection order
	task automatic select_survivors();
		int ord[MAX_CORNERS];
		int cx[MAX_CORNERS];
		int cy[MAX_CORNERS];
		int kl[MAX_CORNERS];
		int nk, j, k, r;
		bit sup;
		kept_t e;
		nk = 0;
		r = int'(m_radius);
		for (int i = 0; i < count; i++) begin
			j = i;
			while (j > 0 && ss[ord[j-1]] < ss[i]) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = i;
			cx[i] = cell_of(int'(sx[i]), int'(m_width));
			cy[i] = cell_of(int'(sy[i]), int'(m_height));
		end
		for (int i = 0; i < count; i++) begin
			k = ord[i];
			sup = 0;
			for (j = 0; j < nk; j++)
				if (abs_diff(cx[k], cx[kl[j]]) <= r && abs_diff(cy[k], cy[kl[j]]) <= r)
					sup = 1;
			if (!sup) begin
				kl[nk] = k;
				nk++;
			end
		end
		for (j = 0; j < nk; j++) begin
			e.idx = IDX_W'(kl[j]);
			e.x = sx[kl[j]];
			e.y = sy[kl[j]];
			e.score = ss[kl[j]];
			e.last = (j == nk - 1);
			kept_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_height = DIM_W'(480);
			m_width = DIM_W'(640);
			m_radius = RAD_W'(4);
			count = 0;
			fail_count = 0;
			kept_seen = 0;
			sets_seen = 0;
			kept_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				kept_seen++;
				if (kept_q.size() == 0) begin
					$error("unexpected kept beat, index %0d", kept_index);
					fail_count++;
				end else begin
					kept_t e;
					e = kept_q.pop_front();
					if (kept_index !== e.idx) begin
						$error("kept_index expected %0d got %0d", e.idx, kept_index);
						fail_count++;
					end
					if (kept_x !== e.x) begin
						$error("kept_x expected %0d got %0d", e.x, kept_x);
						fail_count++;
					end
					if (kept_y !== e.y) begin
						$error("kept_y expected %0d got %0d", e.y, kept_y);
						fail_count++;
					end
					if (kept_score !== e.score) begin
						$error("kept_score expected %0d got %0d", e.score, kept_score);
						fail_count++;
					end
					if (last_kept !== e.last) begin
						$error("last_kept expected %0d got %0d", e.last, last_kept);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (count < MAX_CORNERS) begin
					sx[count] = corner_x;
					sy[count] = corner_y;
					ss[count] = corner_score;
					count++;
				end
				if (final_corner) begin
					select_survivors();
					count = 0;
					sets_seen++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_HEIGHT: m_height = cfg_data;
					REG_GRID_WIDTH:  m_width = cfg_data;
					REG_RADIUS:      m_radius = cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
		end
		pending = kept_q.size();
	end
endmodule

/* bench/grid_keypoint_nms_test.sv */
module grid_keypoint_nms_test;
	import gkn_pkg::*;

	logic               clk = 0;
	logic               arst_n = 1;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = REG_GRID_HEIGHT;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [COORD_W-1:0] corner_x = '0;
	logic [COORD_W-1:0] corner_y = '0;
	logic [SCORE_W-1:0] corner_score = '0;
	logic               final_corner = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic [IDX_W-1:0]   kept_index;
	logic [COORD_W-1:0] kept_x;
	logic [COORD_W-1:0] kept_y;
	logic [SCORE_W-1:0] kept_score;
	logic               last_kept;
	int fail_count, pending, kept_seen, sets_seen;
	int beats_sent = 0;
	bit quiet = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	grid_keypoint_nms u_top (.*);

	grid_keypoint_nms_checker u_check (.*);

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				out_ready <= 0;
				repeat (n) @(negedge clk);
			end
			out_ready <= 1;
		end
	end

	// valid stays high into the next beat unless the sender idles
	task automatic send_beat(int x, int y, int s, bit fin);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			in_valid <= 0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		corner_x <= COORD_W'(x);
		corner_y <= COORD_W'(y);
		corner_score <= SCORE_W'(s);
		final_corner <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	// wait for every kept beat, then let the block settle before touching config
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic random_set(int n, int span);
		int bx, by;
		bx = $urandom_range(0, 16383);
		by = $urandom_range(0, 16383);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_beat($urandom_range(0, 16383), $urandom_range(0, 16383),
					$urandom_range(0, 65535), i == n - 1);
			else
				send_beat((bx + $urandom_range(0, span)) % 16384,
					(by + $urandom_range(0, span)) % 16384,
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 65535),
					i == n - 1);
		end
	endtask

	initial begin
		arst_n <= 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// single corner at the origin, then one at the far corner
		send_beat(0, 0, 0, 1);
		send_beat(16383, 16383, 65535, 1);
		// equal scores, ties by index; rounding half way between cells
		send_beat(8, 8, 100, 0);
		send_beat(7, 7, 100, 0);
		send_beat(200, 200, 65535, 0);
		send_beat(136, 8, 100, 1);
		drain();
		// tiny grid with zero size saturating to one cell
		write_reg(REG_GRID_HEIGHT, 0);
		write_reg(REG_GRID_WIDTH, 0);
		write_reg(REG_RADIUS, 0);
		send_beat(100, 16383, 5, 0);
		send_beat(16383, 0, 9, 1);
		drain();
		// oversize grid saturates, radius at maximum
		write_reg(REG_GRID_HEIGHT, 2047);
		write_reg(REG_GRID_WIDTH, 1024);
		write_reg(REG_RADIUS, 1023);
		send_beat(5000, 3000, 40000, 0);
		send_beat(16383, 16383, 1, 1);
		drain();
		write_reg(REG_GRID_HEIGHT, 1024);
		write_reg(REG_GRID_WIDTH, 1);
		write_reg(REG_RADIUS, 0);
		random_set(6, 64);
		drain();
		// overfull store, final beat dropped
		write_reg(REG_GRID_HEIGHT, 480);
		write_reg(REG_GRID_WIDTH, 640);
		write_reg(REG_RADIUS, 2);
		random_set(66, 400);
		drain();
		for (int p = 0; p < 8; p++) begin
			write_reg(REG_GRID_HEIGHT, $urandom_range(0, 2047));
			write_reg(REG_GRID_WIDTH, $urandom_range(0, 2047));
			write_reg(REG_RADIUS, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
				: $urandom_range(0, 6));
			if (p >= 6) quiet = 1;
			random_set($urandom_range(1, 3), $urandom_range(0, 1) ? 200 : 3000);
			random_set($urandom_range(1, 3), 600);
			drain();
		end
		$display("sent %0d corner beats in %0d sets, %0d kept beats checked",
			beats_sent, sets_seen, kept_seen);
		if (fail_count == 0)
			$display("PASS grid_keypoint_nms");
		else
			$display("FAIL grid_keypoint_nms");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL grid_keypoint_nms");
		$finish;
	end
endmodule
